>>> sv/gated_activation_unit_assert.svh
// Assertion macros used by the checker module of gated_activation_unit.
// No dependencies.
`ifndef GATED_ACTIVATION_UNIT_ASSERT_SVH
`define GATED_ACTIVATION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gau check failed");

// Next-cycle implication.
`define GAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gau check failed");

`endif

>>> sv/gau_pkg.sv
// Types, constants and fp32 arithmetic functions of the gated activation unit.
// No dependencies.
package gau_pkg;

    localparam int ACT_DEPTH  = 2048;
    localparam int GROUP_SIZE = 32;
    localparam int LANE_STEPS = 5;
    localparam int IDX_STEPS  = 7;

    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = 13;

    localparam int ST_LOAD      = 0;
    localparam int ST_CUBE0     = 1;
    localparam int ST_CUBE1     = 2;
    localparam int ST_CUBE2     = 3;
    localparam int ST_INNER     = 4;
    localparam int ST_SCALE     = 5;
    localparam int ST_ARG       = 6;
    localparam int ST_LOG2      = 7;
    localparam int ST_TRUNC     = 8;
    localparam int ST_FRAC      = 9;
    localparam int ST_POLY0     = 10;
    localparam int ST_POLY1     = 11;
    localparam int ST_POLY2     = 12;
    localparam int ST_EXP       = 13;
    localparam int ST_NUMDEN    = 14;
    localparam int ST_DIV_PREP  = 15;
    localparam int ST_DIV_FIRST = 16;
    localparam int ST_DIV_LAST  = ST_DIV_FIRST + DIV_STEPS - 1;
    localparam int ST_DIV_ROUND = ST_DIV_LAST + 1;
    localparam int ST_SELECT    = ST_DIV_ROUND + 1;
    localparam int ST_GATE      = ST_SELECT + 1;
    localparam int ST_UP        = ST_GATE + 1;
    localparam int ST_PACK      = ST_UP + 1;
    localparam int NUM_STAGES   = ST_PACK + 1;

    localparam logic [31:0] FP_CUBIC   = 32'h3D372713;
    localparam logic [31:0] FP_SQRT2PI = 32'h3F4C422A;
    localparam logic [31:0] FP_LOG2E   = 32'h3FB8AA3B;
    localparam logic [31:0] FP_LN2     = 32'h3F317218;
    localparam logic [31:0] FP_QUAD    = 32'h3E75EC74;
    localparam logic [31:0] FP_HALF    = 32'h3F000000;
    localparam logic [31:0] FP_ONE     = 32'h3F800000;
    localparam logic [31:0] FP_NEG_ONE = 32'hBF800000;
    localparam logic [31:0] FP_TWO     = 32'h40000000;
    localparam logic [31:0] FP_NINE    = 32'h41100000;
    localparam logic [31:0] FP_DEF_NAN = 32'hFFC00000;

    typedef struct packed {
        logic        sel;
        logic [31:0] x;
        logic [31:0] u;
        logic [31:0] h;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [11:0] idx;
        logic        nan_f;
        logic        hi_f;
        logic        lo_f;
        logic [24:0] rem;
        logic [25:0] q;
        logic [23:0] dm;
        logic [11:0] ex;
        logic        sg;
        logic        zr;
    } t_item;

    function automatic logic is_nan(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    function automatic logic [31:0] quiet(logic [31:0] v);
        return {v[31], 8'hFF, 1'b1, v[21:0]};
    endfunction

    function automatic logic [5:0] clz48(logic [47:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    // m has its leading one at bit 26 (or is zero), e is the biased exponent
    function automatic logic [31:0] fp_round(logic s, logic signed [11:0] e,
                                             logic [26:0] m, logic st);
        logic [26:0]        mm;
        logic               stk;
        logic signed [11:0] sh;
        logic               up;
        logic [31:0]        base;
        logic [31:0]        bits;
        mm   = m;
        stk  = st;
        base = 32'd0;
        sh   = 12'sd1 - e;
        if (m == 27'd0) return {s, 31'd0};
        if (e > 12'sd254) return {s, 8'hFF, 23'd0};
        if (e >= 12'sd1) begin
            base = {1'b0, 8'(e[7:0] - 8'd1), 23'd0};
        end else if (sh > 12'sd27) begin
            mm  = 27'd0;
            stk = 1'b1;
        end else begin
            mm  = m >> sh[4:0];
            stk = st | ((m & ((27'd1 << sh[4:0]) - 27'd1)) != 27'd0);
        end
        up   = mm[2] & (mm[1] | mm[0] | stk | mm[3]);
        bits = base + {8'd0, mm[26:3]} + {31'd0, up};
        return {s, bits[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic               s;
        logic [23:0]        ma, mb;
        logic [7:0]         ea, eb;
        logic [47:0]        p, pn;
        logic [5:0]         lz;
        logic signed [11:0] e;
        s  = a[31] ^ b[31];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        p  = ma * mb;
        lz = clz48(p);
        pn = p << lz;
        e  = 12'(ea) + 12'(eb) - 12'd126 - 12'(lz);
        if (is_nan(a)) return quiet(a);
        if (is_nan(b)) return quiet(b);
        if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
            return FP_DEF_NAN;
        if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
        return fp_round(s, e, pn[47:21], pn[20:0] != 21'd0);
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [31:0]        x, y;
        logic [23:0]        mx, my;
        logic [7:0]         ex, ey, d;
        logic [26:0]        ys;
        logic               stk;
        logic [27:0]        xf, yf;
        logic [28:0]        r, rn;
        logic [5:0]         lz;
        logic signed [11:0] e;
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        mx = {x[30:23] != 8'd0, x[22:0]};
        my = {y[30:23] != 8'd0, y[22:0]};
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        if (d > 8'd27) begin
            ys  = 27'd0;
            stk = my != 24'd0;
        end else begin
            ys  = {my, 3'd0} >> d[4:0];
            stk = ({my, 3'd0} & ((27'd1 << d[4:0]) - 27'd1)) != 27'd0;
        end
        xf = {mx, 4'd0};
        yf = {ys, stk};
        if (x[31] == y[31]) r = {1'b0, xf} + {1'b0, yf};
        else                r = {1'b0, xf} - {1'b0, yf};
        lz = clz48({r, 19'd0});
        rn = r << lz;
        e  = 12'(ex) + 12'd1 - 12'(lz);
        if (is_nan(a)) return quiet(a);
        if (is_nan(b)) return quiet(b);
        if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return FP_DEF_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (r == 29'd0) return {a[31] & b[31], 31'd0};
        return fp_round(x[31], e, rn[28:2], rn[1:0] != 2'd0);
    endfunction

    function automatic logic [15:0] to_bf16(logic [31:0] v);
        logic [32:0] s;
        s = {1'b0, v} + 33'h7FFF + {32'd0, v[16]};
        if (is_nan(v)) return v[31:16] | 16'h0040;
        return s[31:16];
    endfunction

    function automatic t_item stage_op(int unsigned stage, t_item it);
        t_item       o;
        logic [4:0]  ln;
        logic [7:0]  et;
        logic [4:0]  sh5;
        logic [7:0]  mag;
        logic [7:0]  ip;
        logic [23:0] ma, mb;
        logic [7:0]  ea, eb;
        logic [5:0]  lza, lzb;
        logic        qb;
        logic [31:0] th;
        o   = it;
        mag = 8'd0;
        case (stage) inside
            ST_LOAD: begin
                ln = it.a[4:0];
                for (int k = LANE_STEPS - 1; k >= 0; k--) begin
                    if (32'(ln) >= (32'(GROUP_SIZE) << k))
                        ln = ln - 5'(32'(GROUP_SIZE) << k);
                end
                o.idx = it.idx + 12'(ln);
                o.a   = 32'd0;
            end
            ST_CUBE0: begin
                for (int k = IDX_STEPS - 1; k >= 0; k--) begin
                    if (32'(o.idx) >= (32'(ACT_DEPTH) << k))
                        o.idx = o.idx - 12'(32'(ACT_DEPTH) << k);
                end
                o.a = fp_mul(FP_CUBIC, it.x);
                o.h = fp_mul(FP_HALF, it.x);
            end
            ST_CUBE1, ST_CUBE2: o.a = fp_mul(it.a, it.x);
            ST_INNER: o.a = fp_add(it.x, it.a);
            ST_SCALE: o.a = fp_mul(FP_SQRT2PI, it.a);
            ST_ARG: begin
                th = it.sel ? it.x : it.a;
                o.b     = th;
                o.nan_f = is_nan(th);
                o.hi_f  = !th[31] && (th[30:0] > FP_NINE[30:0]);
                o.lo_f  = th[31] && (th[30:0] > FP_NINE[30:0]);
                if (it.sel) o.a = {~it.x[31], it.x[30:0]};
                else        o.a = fp_mul(FP_TWO, it.a);
            end
            ST_LOG2: o.a = fp_mul(it.a, FP_LOG2E);
            ST_TRUNC: begin
                et = it.a[30:23];
                if (et < 8'd127) begin
                    o.c = 32'd0;
                end else if (et < 8'd150) begin
                    sh5 = 5'(8'd150 - et);
                    o.c = {it.a[31:23], it.a[22:0] & ~((23'd1 << sh5) - 23'd1)};
                    mag = 8'({1'b1, it.a[22:0]} >> sh5);
                end else begin
                    o.c = it.a;
                end
                ip  = it.a[31] ? 8'(-mag) : mag;
                o.d = {1'b0, 8'(ip + 8'd127), 23'd0};
            end
            ST_FRAC: o.a = fp_add(it.a, {~it.c[31], it.c[30:0]});
            ST_POLY0: begin
                o.c = fp_mul(FP_LN2, it.a);
                o.e = fp_mul(FP_QUAD, it.a);
            end
            ST_POLY1: begin
                o.e = fp_mul(it.e, it.a);
                o.c = fp_add(FP_ONE, it.c);
            end
            ST_POLY2: o.c = fp_add(it.c, it.e);
            ST_EXP: o.c = fp_mul(it.d, it.c);
            ST_NUMDEN: begin
                if (it.sel) begin
                    o.a = it.x;
                    o.e = fp_add(FP_ONE, it.c);
                end else begin
                    o.a = fp_add(it.c, FP_NEG_ONE);
                    o.e = fp_add(it.c, FP_ONE);
                end
            end
            ST_DIV_PREP: begin
                ma   = {it.a[30:23] != 8'd0, it.a[22:0]};
                mb   = {it.e[30:23] != 8'd0, it.e[22:0]};
                ea   = (it.a[30:23] == 8'd0) ? 8'd1 : it.a[30:23];
                eb   = (it.e[30:23] == 8'd0) ? 8'd1 : it.e[30:23];
                lza  = clz48({ma, 24'd0});
                lzb  = clz48({mb, 24'd0});
                o.zr = it.a[30:0] == 31'd0;
                o.sg = it.a[31] ^ it.e[31];
                o.rem = {1'b0, 24'(ma << lza)};
                o.dm  = 24'(mb << lzb);
                o.q   = 26'd0;
                o.ex  = 12'(ea) - 12'(lza) - 12'(eb) + 12'(lzb) + 12'd127;
            end
            [ST_DIV_FIRST:ST_DIV_LAST]: begin
                for (int j = 0; j < DIV_BITS; j++) begin
                    qb = o.rem >= {1'b0, o.dm};
                    if (qb) o.rem = o.rem - {1'b0, o.dm};
                    o.q   = {o.q[24:0], qb};
                    o.rem = {o.rem[23:0], 1'b0};
                end
            end
            ST_DIV_ROUND: begin
                if (it.zr)
                    o.a = {it.sg, 31'd0};
                else if (it.q[25])
                    o.a = fp_round(it.sg, it.ex, {it.q, 1'b0}, it.rem != 25'd0);
                else
                    o.a = fp_round(it.sg, it.ex - 12'sd1, {it.q[24:0], 2'd0},
                                   it.rem != 25'd0);
            end
            ST_SELECT: begin
                if (it.sel) begin
                    if (it.nan_f)     o.a = it.x;
                    else if (it.lo_f) o.a = 32'd0;
                    else if (it.hi_f) o.a = it.x;
                end else begin
                    if (it.nan_f)     th = it.b;
                    else if (it.hi_f) th = FP_ONE;
                    else if (it.lo_f) th = FP_NEG_ONE;
                    else              th = it.a;
                    o.a = fp_add(FP_ONE, th);
                end
            end
            ST_GATE: if (!it.sel) o.a = fp_mul(it.h, it.a);
            ST_UP: o.a = fp_mul(it.a, it.u);
            ST_PACK: o.a = {16'd0, to_bf16(it.a)};
            default: o = it;
        endcase
        return o;
    endfunction

endpackage

>>> sv/gau_stage.sv
// One register stage of the activation pipeline with its valid bit and stall logic.
// Depends on gau_pkg.
module gau_stage #(
    parameter int unsigned STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gau_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output gau_pkg::t_item o_item,
    input  logic           i_ready
);

    logic           r_valid;
    gau_pkg::t_item r_item;
    gau_pkg::t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign n_item  = gau_pkg::stage_op(STAGE, i_item);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

>>> sv/gated_activation_unit.sv
// Gated activation unit: act(gate) * up in fp32, rounded to bfloat16, plus destination index.
// Sustains one request per cycle while the output is not stalled.
// Most stages do one or two fp32 multiplies or adds; the divide runs two quotient bits per stage.
// A stage stalls only when it holds data and the stage after it stalls.
// Synchronous active-low reset clears all stage valid bits and selects GELU.
// Depends on gau_pkg and gau_stage.
module gated_activation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_gate_value,
    input  logic [31:0] i_up_value,
    input  logic [10:0] i_base_offset,
    input  logic [4:0]  i_lane,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_activation_bits,
    output logic [10:0] o_dest_index
);

    localparam int NS = gau_pkg::NUM_STAGES;

    logic           r_act_sel;
    gau_pkg::t_item w_item  [0:NS];
    logic           w_valid [0:NS];
    logic           w_ready [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_sel <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_act_sel <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_item[0]     = '0;
        w_item[0].sel = r_act_sel;
        w_item[0].x   = i_gate_value;
        w_item[0].u   = i_up_value;
        w_item[0].idx = {1'b0, i_base_offset};
        w_item[0].a   = {27'd0, i_lane};
    end

    assign w_valid[0]  = i_valid;
    assign o_ready     = w_ready[0];
    assign w_ready[NS] = i_ready;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        gau_stage #(
            .STAGE (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_item  (w_item[k]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .o_item  (w_item[k+1]),
            .i_ready (w_ready[k+1])
        );
    end

    assign o_valid           = w_valid[NS];
    assign o_activation_bits = w_item[NS].a[15:0];
    assign o_dest_index      = w_item[NS].idx[10:0];

endmodule

>>> sv/gau_checker.sv
// Port-level checks of gated_activation_unit and the bind that attaches them.
// Depends on gated_activation_unit_assert.svh.
`include "gated_activation_unit_assert.svh"

module gau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_activation_bits,
    input logic [10:0] o_dest_index
);

    // an empty output stage lets every upstream stage move
    `GAU_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n, !o_valid, o_ready)
    `GAU_ASSERT_NOW(a_ready_through, i_clk, i_rst_n, i_ready, o_ready)
    `GAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `GAU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready,
        $stable(o_activation_bits) && $stable(o_dest_index))

endmodule

bind gated_activation_unit gau_checker u_gau_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_activation_bits (o_activation_bits),
    .o_dest_index      (o_dest_index)
);

>>> tb/tb_gated_activation_unit.sv
// Self-checking testbench for gated_activation_unit: random and directed requests
// checked against an fp32 predictor of the GELU / SiLU gated product in bfloat16.
// Depends on gau_pkg and the gated_activation_unit RTL.
module tb_gated_activation_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic SEL_GELU = 1'b0;
    localparam logic SEL_SILU = 1'b1;

    typedef struct packed {
        logic [31:0] gate;
        logic [31:0] up;
        logic [10:0] base;
        logic [4:0]  lane;
    } t_req;

    typedef struct packed {
        logic [15:0] bits;
        logic [10:0] idx;
    } t_act_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [31:0] i_gate_value  = '0;
    logic [31:0] i_up_value    = '0;
    logic [10:0] i_base_offset = '0;
    logic [4:0]  i_lane        = '0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [15:0] o_activation_bits;
    logic [10:0] o_dest_index;

    t_req        pending_reqs[$];
    t_act_result expected_acts[$];
    logic        act_sel   = SEL_GELU;
    int          src_idle  = 0;
    int          snk_stall = 0;
    int          idle_cnt  = 0;
    bit          failed    = 0;

    gated_activation_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_gate_value      (i_gate_value),
        .i_up_value        (i_up_value),
        .i_base_offset     (i_base_offset),
        .i_lane            (i_lane),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_activation_bits (o_activation_bits),
        .o_dest_index      (o_dest_index)
    );

    // fp32 <-> double; double holds every fp32 op result exactly enough
    // that a single final round to fp32 is correct.
    function automatic real sp_to_real(logic [31:0] b);
        real r;
        if (b[30:23] == 8'd0) begin
            if (b[22:0] == 23'd0) return $bitstoreal({b[31], 63'd0});
            r = $itor(b[22:0]) * (2.0 ** (-149));
            return b[31] ? -r : r;
        end
        return $bitstoreal({b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'd0});
    endfunction

    function automatic logic [31:0] real_to_sp(real r);
        logic [63:0] d;
        logic [63:0] m, q, rem, half, res;
        int          ebias, sh;
        d = $realtobits(r);
        if (d[62:0] == 63'd0) return {d[63], 31'd0};
        ebias = int'(d[62:52]) - 1023 + 127;
        sh    = (ebias >= 1) ? 29 : 30 - ebias;
        if (sh > 60) return {d[63], 31'd0};
        m    = {11'd0, 1'b1, d[51:0]};
        q    = m >> sh;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        res = (ebias >= 1) ? ((64'(ebias - 1) << 23) + q) : q;
        if (res >= 64'h7F800000) res = 64'h7F800000;
        return {d[63], res[30:0]};
    endfunction

    function automatic bit sp_nan(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 23'd0;
    endfunction

    function automatic bit sp_inf(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] == 23'd0;
    endfunction

    function automatic logic [31:0] sp_quiet(logic [31:0] v);
        return {v[31], 8'hFF, 1'b1, v[21:0]};
    endfunction

    function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
        if (sp_nan(a)) return sp_quiet(a);
        if (sp_nan(b)) return sp_quiet(b);
        if ((sp_inf(a) && b[30:0] == 31'd0) || (sp_inf(b) && a[30:0] == 31'd0))
            return gau_pkg::FP_DEF_NAN;
        if (sp_inf(a) || sp_inf(b)) return {a[31] ^ b[31], 8'hFF, 23'd0};
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {a[31] ^ b[31], 31'd0};
        return real_to_sp(sp_to_real(a) * sp_to_real(b));
    endfunction

    function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
        real s;
        if (sp_nan(a)) return sp_quiet(a);
        if (sp_nan(b)) return sp_quiet(b);
        if (sp_inf(a) && sp_inf(b) && a[31] != b[31]) return gau_pkg::FP_DEF_NAN;
        if (sp_inf(a)) return a;
        if (sp_inf(b)) return b;
        s = sp_to_real(a) + sp_to_real(b);
        if (s == 0.0) return {a[31] & b[31], 31'd0};
        return real_to_sp(s);
    endfunction

    function automatic logic [31:0] sp_div(logic [31:0] a, logic [31:0] b);
        if (sp_nan(a)) return sp_quiet(a);
        if (sp_nan(b)) return sp_quiet(b);
        if (a[30:0] == 31'd0) return {a[31] ^ b[31], 31'd0};
        return real_to_sp(sp_to_real(a) / sp_to_real(b));
    endfunction

    function automatic logic [31:0] approx_exp(logic [31:0] z);
        logic [31:0] t, fr, p2i, lin, q1, q2, s;
        int          ip;
        t   = sp_mul(z, gau_pkg::FP_LOG2E);
        ip  = $rtoi(sp_to_real(t));
        fr  = sp_add(t, real_to_sp(-$itor(ip)));
        p2i = {1'b0, 8'(ip + 127), 23'd0};
        lin = sp_mul(gau_pkg::FP_LN2, fr);
        q1  = sp_mul(gau_pkg::FP_QUAD, fr);
        q2  = sp_mul(q1, fr);
        s   = sp_add(gau_pkg::FP_ONE, lin);
        return sp_mul(p2i, sp_add(s, q2));
    endfunction

    function automatic logic [31:0] approx_tanh(logic [31:0] y);
        logic [31:0] e;
        if (sp_nan(y)) return y;
        if (sp_to_real(y) > 9.0) return gau_pkg::FP_ONE;
        if (sp_to_real(y) < -9.0) return gau_pkg::FP_NEG_ONE;
        e = approx_exp(sp_mul(gau_pkg::FP_TWO, y));
        return sp_div(sp_add(e, gau_pkg::FP_NEG_ONE), sp_add(e, gau_pkg::FP_ONE));
    endfunction

    function automatic logic [31:0] gelu(logic [31:0] x);
        logic [31:0] c;
        c = sp_mul(gau_pkg::FP_CUBIC, x);
        c = sp_mul(sp_mul(c, x), x);
        c = sp_mul(gau_pkg::FP_SQRT2PI, sp_add(x, c));
        return sp_mul(sp_mul(gau_pkg::FP_HALF, x), sp_add(gau_pkg::FP_ONE, approx_tanh(c)));
    endfunction

    function automatic logic [31:0] silu(logic [31:0] x);
        if (sp_nan(x)) return x;
        if (sp_to_real(x) < -9.0) return 32'd0;
        if (sp_to_real(x) > 9.0) return x;
        return sp_div(x, sp_add(gau_pkg::FP_ONE, approx_exp({~x[31], x[30:0]})));
    endfunction

    function automatic logic [15:0] round_bf16(logic [31:0] b);
        logic [32:0] s;
        if (sp_nan(b)) return b[31:16] | 16'h0040;
        s = {1'b0, b} + 33'h7FFF + {32'd0, b[16]};
        return s[31:16];
    endfunction

    function automatic t_act_result gated_act(t_req r, logic sel);
        t_act_result res;
        logic [31:0] a;
        a        = (sel == SEL_SILU) ? silu(r.gate) : gelu(r.gate);
        res.bits = round_bf16(sp_mul(a, r.up));
        res.idx  = 11'((r.base + r.lane) % gau_pkg::ACT_DEPTH);
        return res;
    endfunction

    function automatic logic [31:0] rand_gate();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(9))
            0: ;
            1: v = (v[0] ? 32'hC1100000 : 32'h41100000) + 32'($urandom_range(64)) - 32'd32;
            2: v = {v[31], 8'($urandom_range(126, 131)), v[22:0]};
            default: v = {v[31], 8'($urandom_range(110, 130)), v[22:0]};
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_up();
        logic [31:0] v;
        v = $urandom();
        if ($urandom_range(7) != 0) v = {v[31], 8'($urandom_range(100, 150)), v[22:0]};
        return v;
    endfunction

    task automatic add_req(logic [31:0] g, logic [31:0] u, logic [10:0] b, logic [4:0] l);
        pending_reqs.push_back('{gate: g, up: u, base: b, lane: l});
    endtask

    task automatic add_directed();
        logic [31:0] gates[15];
        gates = '{32'h00000000, 32'h80000000, gau_pkg::FP_ONE, gau_pkg::FP_NEG_ONE,
                  32'h41100000, 32'h41100001, 32'hC1100000, 32'hC1100001, 32'h7F800000,
                  32'hFF800000, 32'h7FC00001, 32'hFF812345, 32'h00000001,
                  32'h7F7FFFFF, 32'hFF7FFFFF};
        foreach (gates[k])
            add_req(gates[k], gau_pkg::FP_ONE, k[0] ? 11'h7FF : 11'h000,
                    k[1] ? 5'h1F : 5'h00);
        add_req(32'h41800000, 32'h7D7FFFFF, 11'h7FF, 5'h1F);   // rounds past max bf16
        add_req(32'h41800000, 32'hFD7FFFFF, 11'h7E1, 5'h1F);
        add_req(gau_pkg::FP_ONE, 32'h7FA00000, 11'h400, 5'h10); // NaN up
        add_req(32'h00000000, 32'h7F800000, 11'h001, 5'h01);    // zero gate times inf
        add_req(32'h40000000, 32'h00000001, 11'h2AA, 5'h15);
        add_req(32'hC0400000, 32'hFFFFFFFF, 11'h555, 5'h0A);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // request driver
    always @(posedge i_clk) begin
        t_req nx;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_acts.push_back(gated_act('{gate: i_gate_value, up: i_up_value,
                    base: i_base_offset, lane: i_lane}, act_sel));
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle) begin
                    nx = pending_reqs.pop_front();
                    i_valid       <= 1'b1;
                    i_gate_value  <= nx.gate;
                    i_up_value    <= nx.up;
                    i_base_offset <= nx.base;
                    i_lane        <= nx.lane;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_act_result exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_acts.size() == 0) begin
                    failed = 1;
                    $display("%0t: unexpected result bits=%h idx=%0d", $realtime,
                             o_activation_bits, o_dest_index);
                end else begin
                    exp_r = expected_acts.pop_front();
                    if (o_activation_bits !== exp_r.bits) begin
                        failed = 1;
                        $display("%0t: activation_bits expected %h actual %h", $realtime,
                                 exp_r.bits, o_activation_bits);
                    end
                    if (o_dest_index !== exp_r.idx) begin
                        failed = 1;
                        $display("%0t: dest_index expected %0d actual %0d", $realtime,
                                 exp_r.idx, o_dest_index);
                    end
                end
            end
            i_ready <= $urandom_range(99) >= snk_stall;
        end
    end

    // watchdog: no progress while work is outstanding
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) ||
            (pending_reqs.size() == 0 && !i_valid && expected_acts.size() == 0))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("tb_gated_activation_unit: FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || expected_acts.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        @(posedge i_rst_n);
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= ph[0] ? SEL_SILU : SEL_GELU;
            act_sel       = ph[0] ? SEL_SILU : SEL_GELU;
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            case (ph / 2)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 49; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 49; end
                default: begin src_idle = 19; snk_stall = 19; end
            endcase
            if (ph < 2) add_directed();
            for (int k = 0; k < 200; k++)
                add_req(rand_gate(), rand_up(), 11'($urandom()), 5'($urandom()));
        end
        wait_drained();
        if (!failed)
            $display("tb_gated_activation_unit: PASS");
        else
            $display("tb_gated_activation_unit: FAIL");
        $finish;
    end

endmodule
